// ===== src/sgr_pkg.sv =====
// Shared types, codes and the xterm color table of the SGR color escape parser.
`timescale 1ns / 1ps

package sgr_pkg;

   localparam logic [1:0] ST_SET   = 2'd0;
   localparam logic [1:0] ST_RESET = 2'd1;
   localparam logic [1:0] ST_ERASE = 2'd2;
   localparam logic [1:0] ST_BAD   = 2'd3;

   localparam logic [1:0] KIND_DEFAULT = 2'd0;
   localparam logic [1:0] KIND_INDEX   = 2'd1;
   localparam logic [1:0] KIND_RGB     = 2'd2;
   localparam logic [1:0] KIND_UNUSED  = 2'd3;

   typedef struct packed {
      logic [1:0]  status;
      logic [1:0]  fg_kind;
      logic [23:0] fg_value;
      logic [1:0]  bg_kind;
      logic [23:0] bg_value;
      logic [3:0]  attribute;
      logic        chained;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [23:0] value;
   } color_type;

   typedef logic [23:0] rgb_table_type [256];
   typedef logic [7:0]  level_table_type [6];
   typedef logic [23:0] base_table_type [16];

   localparam base_table_type BASE16 = '{
      24'h000000, 24'hCD0000, 24'h00CD00, 24'hCDCD00, 24'h0000EE, 24'hCD00CD,
      24'h00CDCD, 24'hE5E5E5, 24'h7F7F7F, 24'hFF0000, 24'h00FF00, 24'hFFFF00,
      24'h5C5CFF, 24'hFF00FF, 24'h00FFFF, 24'hFFFFFF};

   localparam level_table_type CUBE_LEVEL = '{
      8'h00, 8'h5F, 8'h87, 8'hAF, 8'hD7, 8'hFF};

   // Sixteen base colors, then the 6x6x6 cube, then the 24-step gray ramp.
   function automatic rgb_table_type build_xterm_rgb();
      rgb_table_type t;
      int k;
      int g;
      for (int i = 0; i < 256; i++) begin
         if (i < 16) begin
            t[i] = BASE16[i];
         end else if (i < 232) begin
            k = i - 16;
            t[i] = {CUBE_LEVEL[3'((k / 36) % 6)], CUBE_LEVEL[3'((k / 6) % 6)],
                    CUBE_LEVEL[3'(k % 6)]};
         end else begin
            g = 8 + 10 * (i - 232);
            t[i] = {3{8'(g)}};
         end
      end
      return t;
   endfunction

   localparam rgb_table_type XTERM_RGB = build_xterm_rgb();

   // Final form of one color as reported on the result channel.
   function automatic color_type map_color(logic [1:0] kind, logic [23:0] value,
                                           logic true_color);
      color_type c;
      c.kind  = kind;
      c.value = value;
      if (kind == KIND_INDEX && true_color) begin
         c.kind  = KIND_RGB;
         c.value = XTERM_RGB[value[7:0]];
      end else if (kind == KIND_DEFAULT || kind == KIND_UNUSED) begin
         c.kind  = KIND_DEFAULT;
         c.value = 24'h000000;
      end
      return c;
   endfunction

endpackage

// ===== src/sgr_color_escape_parser_top.sv =====
// Top level of the SGR color escape parser: control register, parser and result queue.
`timescale 1ns / 1ps

// Usage: text bytes enter on the req_ channel (req_valid / req_ready /
// req_text_byte), one byte per request. A byte that ends a color sequence,
// a reset (ESC[m), an erase (ESC[K) or a malformed sequence yields one
// result request on the rsp_ channel; every other byte yields none.
// The csr_ channel writes the true-color bit, which turns palette indexes
// into 24-bit RGB through the xterm table; it is always ready and should be
// written only while no byte is in flight.
// Throughput is one byte per cycle while the result queue is not full, set by the
// combinational parse step between the byte register state and the result queue.
// A result is registered in the queue and shows on the rsp_ ports at its head.
// Results wait in a two-entry queue. While the receiver stalls, req_ready
// stays high until both entries hold results, so one more byte (and any
// bytes that produce no result) can be taken meanwhile; req_ready drops only
// when the queue is full.
// Synchronous reset returns the parser to idle outside any sequence, clears
// committed colors to default/default with attribute 0, empties the queue
// and clears the true-color bit.
module sgr_color_escape_parser_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_text_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [1:0]  rsp_fg_kind,
   output logic [23:0] rsp_fg_value,
   output logic [1:0]  rsp_bg_kind,
   output logic [23:0] rsp_bg_value,
   output logic [3:0]  rsp_attribute,
   output logic        rsp_chained,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_true_color_mode
);

   logic                  true_color_ff;
   logic                  accept;
   logic                  parse_valid;
   sgr_pkg::rsp_item_type parse_item;
   logic                  queue_full;
   sgr_pkg::rsp_item_type head_item;
   sgr_pkg::color_type    fg_color, bg_color;

   // The control register takes a write in every cycle.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) true_color_ff <= 1'b0;
      else if (csr_valid) true_color_ff <= csr_true_color_mode;
   end

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   sgr_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .text_byte (req_text_byte),
      .out_valid (parse_valid),
      .out_item  (parse_item)
   );

   sgr_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (parse_valid),
      .in_item   (parse_item),
      .full      (queue_full),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_item  (head_item)
   );

   // Palette indexes are kept as indexes in the parser and queue. The table
   // lookup happens on the way out, since the user must keep the control bit stable
   // while results are pending; the block itself does not enforce it.
   always_comb begin
      fg_color = sgr_pkg::map_color(head_item.fg_kind, head_item.fg_value,
                                    true_color_ff);
      bg_color = sgr_pkg::map_color(head_item.bg_kind, head_item.bg_value,
                                    true_color_ff);
   end

   assign rsp_status    = head_item.status;
   assign rsp_fg_kind   = fg_color.kind;
   assign rsp_fg_value  = fg_color.value;
   assign rsp_bg_kind   = bg_color.kind;
   assign rsp_bg_value  = bg_color.value;
   assign rsp_attribute = head_item.attribute;
   assign rsp_chained   = head_item.chained;

endmodule

// ===== src/sgr_parser.sv =====
// Byte-wise SGR sequence parser: sequence state, working and committed colors.
`timescale 1ns / 1ps

module sgr_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [7:0]            text_byte,
   output logic                  out_valid,
   output sgr_pkg::rsp_item_type out_item
);

   typedef enum logic [3:0] {
      PH_IDLE  = 4'd0,
      PH_ESC   = 4'd1,
      PH_OPEN  = 4'd2,
      PH_PARAM = 4'd3,
      PH_MODE  = 4'd4,
      PH_INDEX = 4'd5,
      PH_RED   = 4'd6,
      PH_GREEN = 4'd7,
      PH_BLUE  = 4'd8
   } phase_type;

   localparam logic [7:0] CH_ESC     = 8'd27;
   localparam logic [7:0] CH_BRACKET = 8'h5B;
   localparam logic [7:0] CH_CLOSE   = 8'h5D;
   localparam logic [7:0] CH_SEMI    = 8'h3B;
   localparam logic [7:0] CH_COLON   = 8'h3A;
   localparam logic [7:0] CH_M       = 8'h6D;
   localparam logic [7:0] CH_K       = 8'h4B;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;

   phase_type   phase_ff, phase_in;
   logic [7:0]  acc_ff, acc_in;
   logic        digits_ff, digits_in;
   logic        ext_bg_ff, ext_bg_in;
   logic [7:0]  red_ff, red_in;
   logic [7:0]  green_ff, green_in;
   logic [1:0]  work_fg_kind_ff, work_fg_kind_in;
   logic [23:0] work_fg_ff, work_fg_in;
   logic [1:0]  work_bg_kind_ff, work_bg_kind_in;
   logic [23:0] work_bg_ff, work_bg_in;
   logic [3:0]  work_attr_ff, work_attr_in;
   logic [1:0]  kept_fg_kind_ff, kept_fg_kind_in;
   logic [23:0] kept_fg_ff, kept_fg_in;
   logic [1:0]  kept_bg_kind_ff, kept_bg_kind_in;
   logic [23:0] kept_bg_ff, kept_bg_in;
   logic [3:0]  kept_attr_ff, kept_attr_in;
   logic        chain_ff, chain_in;

   logic        is_digit, is_sep, is_term;
   logic [11:0] acc_next;
   logic [7:0]  val;
   logic        in_seq, handled, bad, fin;
   phase_type   ph;

   assign is_digit = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);
   assign is_sep   = (text_byte == CH_SEMI) || (text_byte == CH_COLON);
   assign is_term  = (text_byte == CH_M) || (text_byte == CH_CLOSE);
   // Digits 0 to 9 sit in the low nibble of their character codes.
   assign acc_next = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0}
                   + {8'h00, text_byte[3:0]};
   assign val      = digits_ff ? acc_ff : 8'h00;

   always_comb begin
      phase_in        = phase_ff;
      acc_in          = acc_ff;
      digits_in       = digits_ff;
      ext_bg_in       = ext_bg_ff;
      red_in          = red_ff;
      green_in        = green_ff;
      work_fg_kind_in = work_fg_kind_ff;
      work_fg_in      = work_fg_ff;
      work_bg_kind_in = work_bg_kind_ff;
      work_bg_in      = work_bg_ff;
      work_attr_in    = work_attr_ff;
      kept_fg_kind_in = kept_fg_kind_ff;
      kept_fg_in      = kept_fg_ff;
      kept_bg_kind_in = kept_bg_kind_ff;
      kept_bg_in      = kept_bg_ff;
      kept_attr_in    = kept_attr_ff;
      chain_in        = chain_ff;
      out_valid       = 1'b0;
      out_item        = '0;
      in_seq          = 1'b0;
      handled         = 1'b0;
      bad             = 1'b0;
      fin             = 1'b0;
      ph              = phase_ff;

      if (in_valid) begin
         unique case (phase_ff)
            PH_IDLE: begin
               if (text_byte == CH_ESC) phase_in = PH_ESC;
               else chain_in = 1'b0;
            end
            PH_ESC: begin
               if (text_byte == CH_BRACKET) begin
                  if (chain_ff) begin
                     work_fg_kind_in = kept_fg_kind_ff;
                     work_fg_in      = kept_fg_ff;
                     work_bg_kind_in = kept_bg_kind_ff;
                     work_bg_in      = kept_bg_ff;
                     work_attr_in    = kept_attr_ff;
                  end else begin
                     work_fg_kind_in = sgr_pkg::KIND_DEFAULT;
                     work_fg_in      = '0;
                     work_bg_kind_in = sgr_pkg::KIND_DEFAULT;
                     work_bg_in      = '0;
                     work_attr_in    = '0;
                  end
                  acc_in    = '0;
                  digits_in = 1'b0;
                  phase_in  = PH_OPEN;
               end else begin
                  chain_in = 1'b0;
                  if (text_byte != CH_ESC) phase_in = PH_IDLE;
               end
            end
            PH_OPEN, PH_PARAM, PH_MODE, PH_INDEX, PH_RED, PH_GREEN, PH_BLUE: begin
               in_seq = 1'b1;
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase

         // The first byte after the bracket may be a whole reset or erase.
         if (in_seq && phase_ff == PH_OPEN) begin
            if (text_byte == CH_M) begin
               handled         = 1'b1;
               kept_fg_kind_in = sgr_pkg::KIND_DEFAULT;
               kept_fg_in      = '0;
               kept_bg_kind_in = sgr_pkg::KIND_DEFAULT;
               kept_bg_in      = '0;
               kept_attr_in    = '0;
               chain_in        = 1'b0;
               phase_in        = PH_IDLE;
               out_valid       = 1'b1;
               out_item.status = sgr_pkg::ST_RESET;
            end else if (text_byte == CH_K && !chain_ff) begin
               handled         = 1'b1;
               phase_in        = PH_IDLE;
               out_valid       = 1'b1;
               out_item.status = sgr_pkg::ST_ERASE;
            end else begin
               ph       = PH_PARAM;
               phase_in = PH_PARAM;
            end
         end

         if (in_seq && !handled) begin
            if (is_digit) begin
               if (acc_next >= 12'd256) begin
                  bad = 1'b1;
               end else begin
                  acc_in    = acc_next[7:0];
                  digits_in = 1'b1;
               end
            end else if (!is_sep && !is_term) begin
               bad = 1'b1;
            end else begin
               case (ph)
                  PH_PARAM: begin
                     if (val == 8'd38 || val == 8'd48) begin
                        if (!is_sep) begin
                           bad = 1'b1;
                        end else begin
                           ext_bg_in = (val == 8'd48);
                           acc_in    = '0;
                           digits_in = 1'b0;
                           phase_in  = PH_MODE;
                        end
                     end else begin
                        fin = 1'b1;
                        if (val <= 8'd8) begin
                           work_attr_in = val[3:0];
                        end else if (val >= 8'd20 && val <= 8'd29) begin
                           work_attr_in = '0;
                        end else if (val >= 8'd30 && val <= 8'd37) begin
                           work_fg_kind_in = sgr_pkg::KIND_INDEX;
                           work_fg_in      = {16'h0000, val - 8'd30};
                        end else if (val == 8'd39) begin
                           work_fg_kind_in = sgr_pkg::KIND_DEFAULT;
                           work_fg_in      = '0;
                        end else if (val >= 8'd40 && val <= 8'd47) begin
                           work_bg_kind_in = sgr_pkg::KIND_INDEX;
                           work_bg_in      = {16'h0000, val - 8'd40};
                        end else if (val == 8'd49) begin
                           work_bg_kind_in = sgr_pkg::KIND_DEFAULT;
                           work_bg_in      = '0;
                        end else if (val >= 8'd90 && val <= 8'd97) begin
                           work_fg_kind_in = sgr_pkg::KIND_INDEX;
                           work_fg_in      = {16'h0000, val - 8'd82};
                        end else if (val >= 8'd100 && val <= 8'd107) begin
                           work_bg_kind_in = sgr_pkg::KIND_INDEX;
                           work_bg_in      = {16'h0000, val - 8'd92};
                        end
                     end
                  end
                  PH_MODE: begin
                     if (!is_sep || !digits_ff) begin
                        bad = 1'b1;
                     end else if (val == 8'd5) begin
                        phase_in  = PH_INDEX;
                        acc_in    = '0;
                        digits_in = 1'b0;
                     end else if (val == 8'd2) begin
                        phase_in  = PH_RED;
                        acc_in    = '0;
                        digits_in = 1'b0;
                     end else begin
                        bad = 1'b1;
                     end
                  end
                  PH_INDEX: begin
                     fin = 1'b1;
                     if (ext_bg_ff) begin
                        work_bg_kind_in = sgr_pkg::KIND_INDEX;
                        work_bg_in      = {16'h0000, val};
                     end else begin
                        work_fg_kind_in = sgr_pkg::KIND_INDEX;
                        work_fg_in      = {16'h0000, val};
                     end
                  end
                  PH_RED, PH_GREEN: begin
                     if (!is_sep) begin
                        bad = 1'b1;
                     end else begin
                        if (ph == PH_RED) begin
                           red_in   = val;
                           phase_in = PH_GREEN;
                        end else begin
                           green_in = val;
                           phase_in = PH_BLUE;
                        end
                        acc_in    = '0;
                        digits_in = 1'b0;
                     end
                  end
                  default: begin
                     fin = 1'b1;
                     if (ext_bg_ff) begin
                        work_bg_kind_in = sgr_pkg::KIND_RGB;
                        work_bg_in      = {red_ff, green_ff, val};
                     end else begin
                        work_fg_kind_in = sgr_pkg::KIND_RGB;
                        work_fg_in      = {red_ff, green_ff, val};
                     end
                  end
               endcase
            end

            if (bad) begin
               // An offending ESC opens a fresh, unchained sequence at once.
               chain_in           = 1'b0;
               phase_in           = (text_byte == CH_ESC) ? PH_ESC : PH_IDLE;
               acc_in             = '0;
               digits_in          = 1'b0;
               out_valid          = 1'b1;
               out_item.status    = sgr_pkg::ST_BAD;
               out_item.fg_kind   = kept_fg_kind_ff;
               out_item.fg_value  = kept_fg_ff;
               out_item.bg_kind   = kept_bg_kind_ff;
               out_item.bg_value  = kept_bg_ff;
               out_item.attribute = kept_attr_ff;
            end else if (fin) begin
               acc_in    = '0;
               digits_in = 1'b0;
               if (is_sep) begin
                  phase_in = PH_PARAM;
               end else begin
                  kept_fg_kind_in    = work_fg_kind_in;
                  kept_fg_in         = work_fg_in;
                  kept_bg_kind_in    = work_bg_kind_in;
                  kept_bg_in         = work_bg_in;
                  kept_attr_in       = work_attr_in;
                  chain_in           = 1'b1;
                  phase_in           = PH_IDLE;
                  out_valid          = 1'b1;
                  out_item.status    = sgr_pkg::ST_SET;
                  out_item.fg_kind   = work_fg_kind_in;
                  out_item.fg_value  = work_fg_in;
                  out_item.bg_kind   = work_bg_kind_in;
                  out_item.bg_value  = work_bg_in;
                  out_item.attribute = work_attr_in;
                  out_item.chained   = chain_ff;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         acc_ff          <= '0;
         digits_ff       <= 1'b0;
         ext_bg_ff       <= 1'b0;
         red_ff          <= '0;
         green_ff        <= '0;
         work_fg_kind_ff <= sgr_pkg::KIND_DEFAULT;
         work_fg_ff      <= '0;
         work_bg_kind_ff <= sgr_pkg::KIND_DEFAULT;
         work_bg_ff      <= '0;
         work_attr_ff    <= '0;
         kept_fg_kind_ff <= sgr_pkg::KIND_DEFAULT;
         kept_fg_ff      <= '0;
         kept_bg_kind_ff <= sgr_pkg::KIND_DEFAULT;
         kept_bg_ff      <= '0;
         kept_attr_ff    <= '0;
         chain_ff        <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         acc_ff          <= acc_in;
         digits_ff       <= digits_in;
         ext_bg_ff       <= ext_bg_in;
         red_ff          <= red_in;
         green_ff        <= green_in;
         work_fg_kind_ff <= work_fg_kind_in;
         work_fg_ff      <= work_fg_in;
         work_bg_kind_ff <= work_bg_kind_in;
         work_bg_ff      <= work_bg_in;
         work_attr_ff    <= work_attr_in;
         kept_fg_kind_ff <= kept_fg_kind_in;
         kept_fg_ff      <= kept_fg_in;
         kept_bg_kind_ff <= kept_bg_kind_in;
         kept_bg_ff      <= kept_bg_in;
         kept_attr_ff    <= kept_attr_in;
         chain_ff        <= chain_in;
      end
   end

   a_bad_breaks_chain: assert property (@(posedge clock) disable iff (reset)
      out_valid && out_item.status == sgr_pkg::ST_BAD |=> !chain_ff)
      else $error("malformed sequence left the chain open");

   a_set_opens_chain: assert property (@(posedge clock) disable iff (reset)
      out_valid && out_item.status == sgr_pkg::ST_SET
      |=> chain_ff && phase_ff == PH_IDLE && kept_attr_ff == $past(out_item.attribute))
      else $error("completed sequence not committed");

endmodule

// ===== src/sgr_rsp_queue.sv =====
// Two-entry result queue between the parser and the result channel.
`timescale 1ns / 1ps

module sgr_rsp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  sgr_pkg::rsp_item_type in_item,
   output logic                  full,
   output logic                  out_valid,
   input  logic                  out_ready,
   output sgr_pkg::rsp_item_type out_item
);

   sgr_pkg::rsp_item_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign push      = in_valid;
   assign pop       = out_valid && out_ready;
   assign full      = (count_ff == 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + 2'd1;
      else if (pop && !push) count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= in_item;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("result written into a full queue");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("queue count out of range");

   a_drain_last: assert property (@(posedge clock) disable iff (reset)
      count_ff == 2'd1 && pop && !push |=> !out_valid)
      else $error("queue still valid after its last entry left");

endmodule

// ===== sim/tb_sgr_color_escape_parser_top.sv =====
// Self-checking testbench for the SGR color escape parser top level.
`timescale 1ns / 1ps

module tb_sgr_color_escape_parser_top;

   localparam int CLOCK_PERIOD = 10;
   localparam int RESET_CYCLES = 12;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 400000;

   // Bytes with a meaning inside a color sequence.
   localparam logic [7:0] CH_ESC       = 8'd27;
   localparam logic [7:0] CH_OPEN      = "[";
   localparam logic [7:0] CH_CLOSE     = "]";
   localparam logic [7:0] CH_FINAL_M   = "m";
   localparam logic [7:0] CH_ERASE     = "K";
   localparam logic [7:0] CH_SEMICOLON = ";";
   localparam logic [7:0] CH_COLON     = ":";
   localparam logic [7:0] CH_ZERO      = "0";
   localparam logic [7:0] CH_NINE      = "9";

   // SGR parameter codes and the modes of the extended color selections.
   localparam int unsigned PARAM_LIMIT        = 256;
   localparam int unsigned SGR_ATTR_LAST      = 8;
   localparam int unsigned SGR_ATTR_OFF_FIRST = 20;
   localparam int unsigned SGR_ATTR_OFF_LAST  = 29;
   localparam int unsigned SGR_FG_BASE        = 30;
   localparam int unsigned SGR_FG_EXT         = 38;
   localparam int unsigned SGR_FG_DEFAULT     = 39;
   localparam int unsigned SGR_BG_BASE        = 40;
   localparam int unsigned SGR_BG_EXT         = 48;
   localparam int unsigned SGR_BG_DEFAULT     = 49;
   localparam int unsigned SGR_FG_BRIGHT      = 90;
   localparam int unsigned SGR_BG_BRIGHT      = 100;
   localparam int unsigned EXT_PALETTE        = 5;
   localparam int unsigned EXT_RGB            = 2;

   // Tracks the parser state byte by byte, queues the result each byte should
   // produce and compares the results that come back in order.
   class sgr_scoreboard;
      typedef enum logic [3:0] {
         P_IDLE, P_ESC, P_OPEN, P_CODE, P_MODE, P_INDEX, P_RED, P_GREEN, P_BLUE
      } parse_phase_type;

      logic                  true_color;
      parse_phase_type       phase;
      int unsigned           number;
      logic                  have_digits;
      logic                  to_bg;
      logic [7:0]            red_hold, green_hold;
      logic [1:0]            work_fg_kind, work_bg_kind, kept_fg_kind, kept_bg_kind;
      logic [23:0]           work_fg, work_bg, kept_fg, kept_bg;
      logic [3:0]            work_attr, kept_attr;
      logic                  chain_open;
      sgr_pkg::rsp_item_type sgr_results_due[$];
      int                    errors;
      int                    status_seen[4];

      function new();
         true_color   = 1'b0;
         phase        = P_IDLE;
         number       = 0;
         have_digits  = 1'b0;
         to_bg        = 1'b0;
         red_hold     = '0;
         green_hold   = '0;
         work_fg_kind = sgr_pkg::KIND_DEFAULT;
         work_bg_kind = sgr_pkg::KIND_DEFAULT;
         kept_fg_kind = sgr_pkg::KIND_DEFAULT;
         kept_bg_kind = sgr_pkg::KIND_DEFAULT;
         work_fg      = '0;
         work_bg      = '0;
         kept_fg      = '0;
         kept_bg      = '0;
         work_attr    = '0;
         kept_attr    = '0;
         chain_open   = 1'b0;
         errors       = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
      endfunction

      function logic [7:0] cube_level(int unsigned step);
         return (step == 0) ? 8'h00 : 8'(55 + 40 * step);
      endfunction

      // RGB of an xterm palette entry: 16 base colors, 6x6x6 cube, gray ramp.
      function logic [23:0] xterm_color(logic [7:0] idx);
         int unsigned k;
         logic [7:0]  gray;
         if (idx < 16) begin
            case (idx[3:0])
               4'd0:  return 24'h000000;
               4'd1:  return 24'hCD0000;
               4'd2:  return 24'h00CD00;
               4'd3:  return 24'hCDCD00;
               4'd4:  return 24'h0000EE;
               4'd5:  return 24'hCD00CD;
               4'd6:  return 24'h00CDCD;
               4'd7:  return 24'hE5E5E5;
               4'd8:  return 24'h7F7F7F;
               4'd9:  return 24'hFF0000;
               4'd10: return 24'h00FF00;
               4'd11: return 24'hFFFF00;
               4'd12: return 24'h5C5CFF;
               4'd13: return 24'hFF00FF;
               4'd14: return 24'h00FFFF;
               default: return 24'hFFFFFF;
            endcase
         end
         if (idx < 232) begin
            k = idx - 16;
            return {cube_level(k / 36), cube_level((k / 6) % 6), cube_level(k % 6)};
         end
         gray = 8'(8 + 10 * (idx - 232));
         return {gray, gray, gray};
      endfunction

      // A color as it shows on the result ports under the current mode.
      function sgr_pkg::color_type shown_color(logic [1:0] kind, logic [23:0] value);
         sgr_pkg::color_type c;
         if (kind == sgr_pkg::KIND_INDEX && true_color) begin
            c.kind  = sgr_pkg::KIND_RGB;
            c.value = xterm_color(value[7:0]);
         end else if (kind == sgr_pkg::KIND_INDEX || kind == sgr_pkg::KIND_RGB) begin
            c.kind  = kind;
            c.value = value;
         end else begin
            c.kind  = sgr_pkg::KIND_DEFAULT;
            c.value = '0;
         end
         return c;
      endfunction

      function void add_due(logic [1:0] st, logic [1:0] fk, logic [23:0] fv,
                            logic [1:0] bk, logic [23:0] bv, logic [3:0] attr,
                            logic chained);
         sgr_pkg::rsp_item_type r;
         sgr_pkg::color_type    fg, bg;
         fg          = shown_color(fk, fv);
         bg          = shown_color(bk, bv);
         r.status    = st;
         r.fg_kind   = fg.kind;
         r.fg_value  = fg.value;
         r.bg_kind   = bg.kind;
         r.bg_value  = bg.value;
         r.attribute = attr;
         r.chained   = chained;
         sgr_results_due.push_back(r);
      endfunction

      function void clear_number();
         number      = 0;
         have_digits = 1'b0;
      endfunction

      // A bad sequence reports the committed colors; an offending ESC opens
      // a fresh sequence right away.
      function void reject(logic [7:0] b);
         chain_open = 1'b0;
         phase      = (b == CH_ESC) ? P_ESC : P_IDLE;
         clear_number();
         add_due(sgr_pkg::ST_BAD, kept_fg_kind, kept_fg, kept_bg_kind, kept_bg,
                 kept_attr, 1'b0);
      endfunction

      function void commit();
         logic was_chained;
         was_chained  = chain_open;
         kept_fg_kind = work_fg_kind;
         kept_fg      = work_fg;
         kept_bg_kind = work_bg_kind;
         kept_bg      = work_bg;
         kept_attr    = work_attr;
         chain_open   = 1'b1;
         phase        = P_IDLE;
         clear_number();
         add_due(sgr_pkg::ST_SET, kept_fg_kind, kept_fg, kept_bg_kind, kept_bg,
                 kept_attr, was_chained);
      endfunction

      function void set_target(logic [1:0] kind, logic [23:0] value);
         if (to_bg) begin
            work_bg_kind = kind;
            work_bg      = value;
         end else begin
            work_fg_kind = kind;
            work_fg      = value;
         end
      endfunction

      function void apply_code(int unsigned c);
         if (c <= SGR_ATTR_LAST) begin
            work_attr = 4'(c);
         end else if (c >= SGR_ATTR_OFF_FIRST && c <= SGR_ATTR_OFF_LAST) begin
            work_attr = '0;
         end else if (c >= SGR_FG_BASE && c < SGR_FG_BASE + 8) begin
            work_fg_kind = sgr_pkg::KIND_INDEX;
            work_fg      = 24'(c - SGR_FG_BASE);
         end else if (c == SGR_FG_DEFAULT) begin
            work_fg_kind = sgr_pkg::KIND_DEFAULT;
            work_fg      = '0;
         end else if (c >= SGR_BG_BASE && c < SGR_BG_BASE + 8) begin
            work_bg_kind = sgr_pkg::KIND_INDEX;
            work_bg      = 24'(c - SGR_BG_BASE);
         end else if (c == SGR_BG_DEFAULT) begin
            work_bg_kind = sgr_pkg::KIND_DEFAULT;
            work_bg      = '0;
         end else if (c >= SGR_FG_BRIGHT && c < SGR_FG_BRIGHT + 8) begin
            work_fg_kind = sgr_pkg::KIND_INDEX;
            work_fg      = 24'(c - SGR_FG_BRIGHT + 8);
         end else if (c >= SGR_BG_BRIGHT && c < SGR_BG_BRIGHT + 8) begin
            work_bg_kind = sgr_pkg::KIND_INDEX;
            work_bg      = 24'(c - SGR_BG_BRIGHT + 8);
         end
      endfunction

      // Advances the parser by one accepted text byte.
      function void parse_text_byte(logic [7:0] b);
         logic        is_sep, is_term, is_digit;
         int unsigned grown, param;
         is_sep   = (b == CH_SEMICOLON) || (b == CH_COLON);
         is_term  = (b == CH_FINAL_M) || (b == CH_CLOSE);
         is_digit = (b >= CH_ZERO) && (b <= CH_NINE);

         if (phase == P_IDLE) begin
            if (b == CH_ESC) phase = P_ESC;
            else chain_open = 1'b0;
            return;
         end
         if (phase == P_ESC) begin
            if (b == CH_OPEN) begin
               // A sequence right after a completed one starts from its colors.
               if (chain_open) begin
                  work_fg_kind = kept_fg_kind;
                  work_fg      = kept_fg;
                  work_bg_kind = kept_bg_kind;
                  work_bg      = kept_bg;
                  work_attr    = kept_attr;
               end else begin
                  work_fg_kind = sgr_pkg::KIND_DEFAULT;
                  work_fg      = '0;
                  work_bg_kind = sgr_pkg::KIND_DEFAULT;
                  work_bg      = '0;
                  work_attr    = '0;
               end
               clear_number();
               phase = P_OPEN;
            end else begin
               chain_open = 1'b0;
               if (b != CH_ESC) phase = P_IDLE;
            end
            return;
         end
         if (phase == P_OPEN) begin
            if (b == CH_FINAL_M) begin
               kept_fg_kind = sgr_pkg::KIND_DEFAULT;
               kept_fg      = '0;
               kept_bg_kind = sgr_pkg::KIND_DEFAULT;
               kept_bg      = '0;
               kept_attr    = '0;
               chain_open   = 1'b0;
               phase        = P_IDLE;
               add_due(sgr_pkg::ST_RESET, sgr_pkg::KIND_DEFAULT, '0,
                       sgr_pkg::KIND_DEFAULT, '0, '0, 1'b0);
               return;
            end
            if (b == CH_ERASE && !chain_open) begin
               phase = P_IDLE;
               add_due(sgr_pkg::ST_ERASE, sgr_pkg::KIND_DEFAULT, '0,
                       sgr_pkg::KIND_DEFAULT, '0, '0, 1'b0);
               return;
            end
            phase = P_CODE;
         end

         if (is_digit) begin
            grown = number * 10 + (b - CH_ZERO);
            if (grown >= PARAM_LIMIT) begin
               reject(b);
               return;
            end
            number      = grown;
            have_digits = 1'b1;
            return;
         end
         if (!is_sep && !is_term) begin
            reject(b);
            return;
         end

         param = have_digits ? number : 0;
         case (phase)
            P_CODE: begin
               if (param == SGR_FG_EXT || param == SGR_BG_EXT) begin
                  if (!is_sep) begin
                     reject(b);
                     return;
                  end
                  to_bg = (param == SGR_BG_EXT);
                  clear_number();
                  phase = P_MODE;
                  return;
               end
               apply_code(param);
            end
            P_MODE: begin
               if (!is_sep || !have_digits) begin
                  reject(b);
                  return;
               end
               if (param == EXT_PALETTE) begin
                  phase = P_INDEX;
               end else if (param == EXT_RGB) begin
                  phase = P_RED;
               end else begin
                  reject(b);
                  return;
               end
               clear_number();
               return;
            end
            P_INDEX: set_target(sgr_pkg::KIND_INDEX, 24'(param));
            P_RED, P_GREEN: begin
               if (!is_sep) begin
                  reject(b);
                  return;
               end
               if (phase == P_RED) begin
                  red_hold = param[7:0];
                  phase    = P_GREEN;
               end else begin
                  green_hold = param[7:0];
                  phase      = P_BLUE;
               end
               clear_number();
               return;
            end
            default: set_target(sgr_pkg::KIND_RGB, {red_hold, green_hold, param[7:0]});
         endcase

         clear_number();
         if (is_sep) phase = P_CODE;
         else commit();
      endfunction

      function void compare_field(string field, logic [23:0] want, logic [23:0] got);
         if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            errors++;
         end
      endfunction

      function void check_sgr_result(sgr_pkg::rsp_item_type got);
         sgr_pkg::rsp_item_type want;
         if (sgr_results_due.size() == 0) begin
            $error("result with status %0d arrived while none was due", got.status);
            errors++;
            return;
         end
         want = sgr_results_due.pop_front();
         status_seen[want.status]++;
         compare_field("status", 24'(want.status), 24'(got.status));
         compare_field("fg_kind", 24'(want.fg_kind), 24'(got.fg_kind));
         compare_field("fg_value", want.fg_value, got.fg_value);
         compare_field("bg_kind", 24'(want.bg_kind), 24'(got.bg_kind));
         compare_field("bg_value", want.bg_value, got.bg_value);
         compare_field("attribute", 24'(want.attribute), 24'(got.attribute));
         compare_field("chained", 24'(want.chained), 24'(got.chained));
      endfunction
   endclass

   typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_BURSTY} rx_pattern_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_text_byte = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [1:0]  rsp_fg_kind;
   logic [23:0] rsp_fg_value;
   logic [1:0]  rsp_bg_kind;
   logic [23:0] rsp_bg_value;
   logic [3:0]  rsp_attribute;
   logic        rsp_chained;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_true_color_mode = 1'b0;

   sgr_scoreboard  sb;
   logic [7:0]     text_q[$];
   int             burst_left = 0;
   int             bytes_sent = 0;
   int             cycle_count = 0;
   rx_pattern_type rx_pattern = RX_OPEN;
   int unsigned    rx_pattern_left = 0;
   int unsigned    rx_stall_left = 0;

   sgr_color_escape_parser_top DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_text_byte       (req_text_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_fg_kind         (rsp_fg_kind),
      .rsp_fg_value        (rsp_fg_value),
      .rsp_bg_kind         (rsp_bg_kind),
      .rsp_bg_value        (rsp_bg_value),
      .rsp_attribute       (rsp_attribute),
      .rsp_chained         (rsp_chained),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_true_color_mode (csr_true_color_mode)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Watchdog: a hung handshake or a missing result ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Monitor. A result can never belong to the byte taken at the same edge,
   // so results are checked before the new byte is fed to the scoreboard.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            sb.check_sgr_result({rsp_status, rsp_fg_kind, rsp_fg_value, rsp_bg_kind,
                                 rsp_bg_value, rsp_attribute, rsp_chained});
         if (req_valid && req_ready)
            sb.parse_text_byte(req_text_byte);
      end
   end

   // Result receiver. It switches at random between patterns:
   // always ready, coin toss, mostly stalled, and long stalls between runs.
   always @(posedge clock) begin
      if (rx_pattern_left == 0) begin
         rx_pattern      <= rx_pattern_type'($urandom_range(0, 3));
         rx_pattern_left <= $urandom_range(40, 300);
      end else begin
         rx_pattern_left <= rx_pattern_left - 1;
      end
      if (rx_stall_left != 0) begin
         rsp_ready     <= 1'b0;
         rx_stall_left <= rx_stall_left - 1;
      end else begin
         case (rx_pattern)
            RX_OPEN:   rsp_ready <= 1'b1;
            RX_COIN:   rsp_ready <= ($urandom_range(0, 1) == 1);
            RX_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: begin
               if ($urandom_range(0, 7) == 0) begin
                  rx_stall_left <= $urandom_range(1, 20);
                  rsp_ready     <= 1'b0;
               end else begin
                  rsp_ready <= 1'b1;
               end
            end
         endcase
      end
   end

   // Text building. Everything lands in text_q and is sent in one go.
   function automatic void add_byte(logic [7:0] b);
      text_q.push_back(b);
   endfunction

   function automatic void add_text(string s);
      for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
   endfunction

   // Decimal parameter; now and then with a leading zero, which the parser
   // must absorb without changing the value.
   function automatic void add_number(int unsigned n);
      if ($urandom_range(0, 15) == 0) add_byte(CH_ZERO);
      add_text($sformatf("%0d", n));
   endfunction

   function automatic void add_sep();
      add_byte(($urandom_range(0, 1) == 1) ? CH_SEMICOLON : CH_COLON);
   endfunction

   function automatic void add_term();
      add_byte(($urandom_range(0, 1) == 1) ? CH_FINAL_M : CH_CLOSE);
   endfunction

   function automatic int unsigned ext_code();
      return ($urandom_range(0, 1) == 1) ? SGR_BG_EXT : SGR_FG_EXT;
   endfunction

   // One plain SGR code from the classes the parser acts on.
   function automatic int unsigned pick_code();
      int unsigned v;
      v = $urandom_range(0, 8);
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, SGR_ATTR_LAST);
         1: return $urandom_range(SGR_ATTR_OFF_FIRST, SGR_ATTR_OFF_LAST);
         2: return (v == 8) ? SGR_FG_DEFAULT : SGR_FG_BASE + v;
         3: return (v == 8) ? SGR_BG_DEFAULT : SGR_BG_BASE + v;
         4: return SGR_FG_BRIGHT + v % 8;
         default: return SGR_BG_BRIGHT + v % 8;
      endcase
   endfunction

   function automatic void add_param();
      case ($urandom_range(0, 9))
         0: ;
         1, 2, 3: add_number(pick_code());
         4: add_number($urandom_range(0, 255));
         5, 6: begin
            add_number(ext_code());
            add_sep();
            add_number(EXT_PALETTE);
            add_sep();
            add_number($urandom_range(0, 255));
         end
         default: begin
            add_number(ext_code());
            add_sep();
            add_number(EXT_RGB);
            for (int i = 0; i < 3; i++) begin
               add_sep();
               add_number($urandom_range(0, 255));
            end
         end
      endcase
   endfunction

   function automatic void add_good_sequence();
      int n;
      n = $urandom_range(0, 5);
      add_byte(CH_ESC);
      add_byte(CH_OPEN);
      for (int i = 0; i < n; i++) begin
         if (i > 0) add_sep();
         add_param();
      end
      add_term();
   endfunction

   // A sequence that goes wrong partway: oversized number, extended color
   // cut short, bad or empty mode, early terminator, or a stray byte.
   function automatic void add_broken_sequence();
      add_byte(CH_ESC);
      add_byte(CH_OPEN);
      if ($urandom_range(0, 1) == 1) begin
         add_param();
         add_sep();
      end
      case ($urandom_range(0, 5))
         0: add_number($urandom_range(PARAM_LIMIT, 999));
         1: add_number(ext_code());
         2: begin
            add_number(ext_code());
            add_sep();
            add_sep();
         end
         3: begin
            add_number(ext_code());
            add_sep();
            add_number($urandom_range(0, 255));
            add_sep();
         end
         4: begin
            add_number(ext_code());
            add_sep();
            add_number(EXT_RGB);
            add_sep();
            add_number($urandom_range(0, 255));
            if ($urandom_range(0, 1) == 1) begin
               add_sep();
               add_number($urandom_range(0, 255));
            end
         end
         default: add_byte(8'($urandom_range(0, 255)));
      endcase
      if ($urandom_range(0, 1) == 1) add_term();
   endfunction

   // One random chunk of the stream. About half the time no text follows,
   // so the next sequence chains onto this one.
   function automatic void build_chunk();
      int sel;
      sel = $urandom_range(0, 99);
      text_q.delete();
      if (sel < 55) begin
         add_good_sequence();
      end else if (sel < 63) begin
         add_byte(CH_ESC);
         add_text("[m");
      end else if (sel < 70) begin
         add_byte(CH_ESC);
         add_text("[K");
      end else if (sel < 82) begin
         add_broken_sequence();
      end else if (sel < 90) begin
         add_byte(CH_ESC);
         if ($urandom_range(0, 1) == 1) begin
            add_byte(8'($urandom_range(0, 255)));
         end else begin
            add_byte(CH_ESC);
            add_text("[");
            add_param();
            add_term();
         end
      end else begin
         for (int i = $urandom_range(1, 6); i > 0; i--)
            add_byte(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 1) == 1)
         for (int i = $urandom_range(1, 3); i > 0; i--)
            add_byte(8'($urandom_range(0, 255)));
   endfunction

   // Sends one byte as a request. The sender works in bursts; between bursts
   // valid drops for a random gap, sometimes of zero length.
   task automatic send_byte(input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 48);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid     <= 1'b1;
      req_text_byte <= b;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
   endtask

   task automatic send_text();
      foreach (text_q[i]) send_byte(text_q[i]);
   endtask

   // Waits until every due result is back, then lets the parser settle.
   // The first edge lets the monitor take in the byte accepted last.
   task automatic wait_drained();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (sb.sgr_results_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input logic mode);
      wait_drained();
      csr_valid           <= 1'b1;
      csr_true_color_mode <= mode;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.true_color = mode;
   endtask

   task automatic run_random(input int target);
      int start;
      start = bytes_sent;
      while (bytes_sent - start < target) begin
         build_chunk();
         send_text();
      end
   endtask

   initial begin
      sb = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      write_mode(1'b0);

      // Directed opening: reset, erase, an oversized number, the byte
      // extremes outside any sequence, bright colors, and an erase that
      // chains onto a completed sequence, which must come back malformed.
      text_q.delete();
      add_byte(CH_ESC);
      add_text("[m");
      add_byte(CH_ESC);
      add_text("[K");
      add_byte(CH_ESC);
      add_text("[256");
      add_byte(8'h00);
      add_byte(8'hFF);
      add_byte(CH_ESC);
      add_text("[97;107m");
      add_byte(CH_ESC);
      add_text("[K");
      send_text();

      run_random(700);
      write_mode(1'b1);
      run_random(700);
      write_mode(1'b0);
      run_random(600);
      wait_drained();

      $display("Sent %0d text bytes in palette and true-color modes; results checked:",
               bytes_sent);
      $display("  %0d color sets, %0d resets, %0d erases, %0d malformed.",
               sb.status_seen[sgr_pkg::ST_SET], sb.status_seen[sgr_pkg::ST_RESET],
               sb.status_seen[sgr_pkg::ST_ERASE], sb.status_seen[sgr_pkg::ST_BAD]);
      if (sb.errors == 0 && sb.sgr_results_due.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
